// ===== design/hhet_pkg.sv =====
// ----------------------------------------------------------------------------
// hhet_pkg
// Shared types and constants of the hashed handle event table: field widths,
// command and status codes, and the control and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package hhet_pkg;

   // Defaults of the top-level parameters
   localparam int MAX_ENTRIES_DEF  = 128;
   localparam int HASH_BITS_DEF    = 8;
   localparam int BUCKET_DEPTH_DEF = 2;

   // Fixed field widths of the channels
   localparam int CMD_W      = 2;
   localparam int HANDLE_W   = 16;
   localparam int EVENT_W    = 16;
   localparam int STATUS_W   = 2;
   localparam int SLOT_OUT_W = 7;
   localparam int USED_OUT_W = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_SET    = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 2'd0,
      ST_TABLE_FULL  = 2'd1,
      ST_BUCKET_FULL = 2'd2,
      ST_NOT_FOUND   = 2'd3
   } status_type;

   // Datapath operation issued by the controller in each cycle
   typedef enum logic [3:0] {
      OP_IDLE,
      OP_ACCEPT,
      OP_LOOK,
      OP_DLAST,
      OP_EROW,
      OP_BRD,
      OP_BFIX,
      OP_EV,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type op;
      logic   out_load;
   } ctl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    found;
      logic    has_last;
      logic    clr_last;
   } sts_type;

endpackage

// ===== design/hhet_if.sv =====
// ----------------------------------------------------------------------------
// hhet_if
// Valid/ready channels of the hashed handle event table: the request channel
// and the response channel.
// ----------------------------------------------------------------------------
interface hhet_req_if import hhet_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [HANDLE_W-1:0] handle;
   logic [EVENT_W-1:0]  event_bits;

   modport source (output valid, command, handle, event_bits, input ready);
   modport sink   (input valid, command, handle, event_bits, output ready);
endinterface

interface hhet_rsp_if import hhet_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [SLOT_OUT_W-1:0] slot;
   logic [EVENT_W-1:0]    events_now;
   logic [USED_OUT_W-1:0] entries_used;

   modport source (output valid, status, slot, events_now, entries_used, input ready);
   modport sink   (input valid, status, slot, events_now, entries_used, output ready);
endinterface

// ===== design/hhet_ctrl.sv =====
// ----------------------------------------------------------------------------
// hhet_ctrl
// Command sequencer: steps each request through bucket and dense table
// accesses and owns the response valid flag.
// ----------------------------------------------------------------------------
module hhet_ctrl import hhet_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output ctl_type ctl,
   input  sts_type sts
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOK,
      S_DLAST,
      S_EROW,
      S_BRD,
      S_BFIX,
      S_EV,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_load;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_load  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      ctl.out_load = out_load;
      unique case (state_ff)
         S_CLEAR: ctl.op = OP_CLEAR;
         S_IDLE:  ctl.op = accept ? OP_ACCEPT : OP_IDLE;
         S_LOOK:  ctl.op = OP_LOOK;
         S_DLAST: ctl.op = OP_DLAST;
         S_EROW:  ctl.op = OP_EROW;
         S_BRD:   ctl.op = OP_BRD;
         S_BFIX:  ctl.op = OP_BFIX;
         S_EV:    ctl.op = OP_EV;
         default: ctl.op = OP_IDLE;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
      unique case (state_ff)
         S_CLEAR: begin
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            priority if (sts.cmd == CMD_ADD || !sts.found) begin
               state_in = S_OUT;
            end else if (sts.cmd == CMD_DELETE) begin
               state_in = sts.has_last ? S_DLAST : S_BRD;
            end else begin
               state_in = S_EV;
            end
         end
         S_DLAST: state_in = S_EROW;
         S_EROW:  state_in = S_BRD;
         S_BRD:   state_in = S_BFIX;
         S_BFIX:  state_in = S_OUT;
         S_EV:    state_in = S_OUT;
         S_OUT: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_to_look: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_LOOK))
      else $error("accepted request did not move to lookup");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff)
      else $error("loaded response not presented");

   a_delete_moves_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOK && sts.cmd == CMD_DELETE && sts.found && sts.has_last)
      |=> (state_ff == S_DLAST))
      else $error("delete skipped the move of the last entry");

endmodule

// ===== design/hhet_dp.sv =====
// ----------------------------------------------------------------------------
// hhet_dp
// Datapath: bucket row memory, dense handle/event memory, entry count,
// request and result registers, and the response payload register.
// ----------------------------------------------------------------------------
module hhet_dp import hhet_pkg::*; #(
   parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF,
   parameter int HASH_BITS    = HASH_BITS_DEF,
   parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_type               ctl,
   output sts_type               sts,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [HANDLE_W-1:0]   req_handle,
   input  logic [EVENT_W-1:0]    req_event_bits,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [SLOT_OUT_W-1:0] rsp_slot,
   output logic [EVENT_W-1:0]    rsp_events_now,
   output logic [USED_OUT_W-1:0] rsp_entries_used
);

   localparam int SLOT_W   = $clog2(MAX_ENTRIES);
   localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
   localparam int FILL_W   = $clog2(BUCKET_DEPTH + 1);
   localparam int POS_W    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
   localparam int NBUCKETS = 1 << HASH_BITS;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [SLOT_W-1:0]   slot;
   } pair_type;

   typedef struct packed {
      logic [FILL_W-1:0]                fill;
      pair_type [BUCKET_DEPTH-1:0]      pairs;
   } row_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [EVENT_W-1:0]  events;
   } dense_type;

   // Memories
   row_type   row_mem_ff   [NBUCKETS];
   dense_type dense_mem_ff [MAX_ENTRIES];
   row_type   row_rd_ff;
   dense_type dense_rd_ff;

   logic                 row_we;
   logic [HASH_BITS-1:0] row_wa, row_ra;
   row_type              row_wd;
   logic                 dense_we;
   logic [SLOT_W-1:0]    dense_wa, dense_ra;
   dense_type            dense_wd;

   // Working registers
   cmd_type              cmd_ff, cmd_in;
   logic [HANDLE_W-1:0]  handle_ff, handle_in;
   logic [EVENT_W-1:0]   ev_ff, ev_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [HANDLE_W-1:0]  eh_ff, eh_in;
   logic [HASH_BITS-1:0] clr_addr_ff, clr_addr_in;
   status_type           res_status_ff, res_status_in;
   logic [SLOT_W-1:0]    res_slot_ff, res_slot_in;
   logic [EVENT_W-1:0]   res_events_ff, res_events_in;

   // Response payload
   status_type            out_status_ff;
   logic [SLOT_OUT_W-1:0] out_slot_ff;
   logic [EVENT_W-1:0]    out_events_ff;
   logic [USED_OUT_W-1:0] out_used_ff;

   // Bucket search
   logic [HANDLE_W-1:0] key;
   logic                found;
   logic [POS_W-1:0]    mpos;
   pair_type            mpair;
   logic [FILL_W-1:0]   last_fill;
   logic [EVENT_W-1:0]  new_events;

   always_comb begin
      key   = (ctl.op == OP_EROW) ? eh_ff : handle_ff;
      found = 1'b0;
      mpos  = '0;
      // scan down so the lowest matching position wins
      for (int i = BUCKET_DEPTH - 1; i >= 0; i--) begin
         if (FILL_W'(i) < row_rd_ff.fill && row_rd_ff.pairs[i].handle == key) begin
            found = 1'b1;
            mpos  = POS_W'(i);
         end
      end
      mpair = row_rd_ff.pairs[mpos];
   end

   assign last_fill  = row_rd_ff.fill - FILL_W'(1);
   assign new_events = (cmd_ff == CMD_SET) ? (dense_rd_ff.events | ev_ff)
                                           : (dense_rd_ff.events & ~ev_ff);

   assign sts.cmd      = cmd_ff;
   assign sts.found    = found;
   assign sts.has_last = (count_ff > CNT_W'(1));
   assign sts.clr_last = (clr_addr_ff == '1);

   always_comb begin
      row_ra        = handle_ff[HASH_BITS-1:0];
      row_we        = 1'b0;
      row_wa        = handle_ff[HASH_BITS-1:0];
      row_wd        = row_rd_ff;
      dense_ra      = slot_ff;
      dense_we      = 1'b0;
      dense_wa      = slot_ff;
      dense_wd      = dense_rd_ff;
      cmd_in        = cmd_ff;
      handle_in     = handle_ff;
      ev_in         = ev_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      slot_in       = slot_ff;
      eh_in         = eh_ff;
      clr_addr_in   = clr_addr_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_events_in = res_events_ff;

      unique case (ctl.op)
         OP_ACCEPT: begin
            row_ra    = req_handle[HASH_BITS-1:0];
            cmd_in    = cmd_type'(req_command);
            handle_in = req_handle;
            ev_in     = req_event_bits;
         end
         OP_LOOK: begin
            res_status_in = ST_OK;
            res_slot_in   = '0;
            res_events_in = '0;
            if (cmd_ff == CMD_ADD) begin
               priority if (count_ff >= CNT_W'(MAX_ENTRIES)) begin
                  res_status_in = ST_TABLE_FULL;
               end else if (row_rd_ff.fill >= FILL_W'(BUCKET_DEPTH)) begin
                  res_status_in = ST_BUCKET_FULL;
               end else begin
                  // append pair to the bucket and entry to the dense table
                  row_we = 1'b1;
                  row_wd.pairs[row_rd_ff.fill[POS_W-1:0]] =
                     '{handle: handle_ff, slot: count_ff[SLOT_W-1:0]};
                  row_wd.fill   = row_rd_ff.fill + FILL_W'(1);
                  dense_we      = 1'b1;
                  dense_wa      = count_ff[SLOT_W-1:0];
                  dense_wd      = '{handle: handle_ff, events: ev_ff};
                  res_slot_in   = count_ff[SLOT_W-1:0];
                  res_events_in = ev_ff;
                  count_in      = count_ff + CNT_W'(1);
               end
            end else if (!found) begin
               res_status_in = ST_NOT_FOUND;
            end else if (cmd_ff == CMD_DELETE) begin
               slot_in     = mpair.slot;
               pos_in      = mpos;
               res_slot_in = mpair.slot;
               dense_ra    = SLOT_W'(count_ff - CNT_W'(1));
               if (count_ff != '0) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end else begin
               slot_in  = mpair.slot;
               dense_ra = mpair.slot;
            end
         end
         OP_DLAST: begin
            // move the last entry into the freed slot
            eh_in    = dense_rd_ff.handle;
            dense_we = 1'b1;
            row_ra   = dense_rd_ff.handle[HASH_BITS-1:0];
         end
         OP_EROW: begin
            // repoint the moved entry's pair
            row_wa = eh_ff[HASH_BITS-1:0];
            if (found) begin
               row_we = 1'b1;
               row_wd.pairs[mpos].slot = slot_ff;
            end
         end
         OP_BFIX: begin
            // drop the pair, fill its position with the last pair
            row_we      = 1'b1;
            row_wd.fill = last_fill;
            if (last_fill != '0) begin
               row_wd.pairs[pos_ff] = row_rd_ff.pairs[last_fill[POS_W-1:0]];
            end
         end
         OP_EV: begin
            dense_we      = 1'b1;
            dense_wd      = '{handle: dense_rd_ff.handle, events: new_events};
            res_status_in = ST_OK;
            res_slot_in   = slot_ff;
            res_events_in = new_events;
         end
         OP_CLEAR: begin
            row_we      = 1'b1;
            row_wa      = clr_addr_ff;
            row_wd      = '0;
            clr_addr_in = clr_addr_ff + HASH_BITS'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem_ff[row_wa] <= row_wd;
      end
      row_rd_ff <= row_mem_ff[row_ra];
      if (dense_we) begin
         dense_mem_ff[dense_wa] <= dense_wd;
      end
      dense_rd_ff <= dense_mem_ff[dense_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         clr_addr_ff <= '0;
      end else begin
         count_ff    <= count_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      handle_ff     <= handle_in;
      ev_ff         <= ev_in;
      pos_ff        <= pos_in;
      slot_ff       <= slot_in;
      eh_ff         <= eh_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_events_ff <= res_events_in;
      if (ctl.out_load) begin
         out_status_ff <= res_status_ff;
         out_slot_ff   <= SLOT_OUT_W'(res_slot_ff);
         out_events_ff <= res_events_ff;
         out_used_ff   <= USED_OUT_W'(count_ff);
      end
   end

   assign rsp_status       = out_status_ff;
   assign rsp_slot         = out_slot_ff;
   assign rsp_events_now   = out_events_ff;
   assign rsp_entries_used = out_used_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count beyond table size");

   a_bfix_nonempty: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == OP_BFIX) |-> (row_rd_ff.fill != '0))
      else $error("bucket compaction on an empty bucket");

   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == OP_LOOK && cmd_ff == CMD_ADD && res_status_in == ST_OK)
      |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("successful add did not grow the table");

endmodule

// ===== design/hashed_handle_event_table_unit.sv =====
// ----------------------------------------------------------------------------
// hashed_handle_event_table_unit
// Dense handle/event-mask table with a bucketed hash index; add, delete,
// set-bits and clear-bits commands, one response per request.
// ----------------------------------------------------------------------------
// Each request carries a command, a 16-bit handle and a 16-bit event mask and
// produces exactly one response with a status, the dense slot involved, the
// entry's event mask after the command and the number of entries in use. The
// handle's low HASH_BITS bits pick a bucket of BUCKET_DEPTH handle/slot pairs
// held as one row of a single-port-write memory; all pairs of a row are
// compared in one cycle. Requests are worked one at a time by a sequencer:
// counted from the transfer of the request to the response being ready, an
// add or any not-found answer takes 3 cycles, set and clear take 4 (one dense
// table read-modify-write), and delete takes 7 (5 when it removes the only
// entry), since the last dense entry must be read, its bucket row read and
// repointed, and the deleted handle's bucket row read again and compacted.
// The response sits in an output register, so the next request is taken while
// the previous response waits. After reset the block walks all 2^HASH_BITS
// bucket rows to zero their fill counts, one row per cycle, and accepts no
// request until that pass is done.
// ----------------------------------------------------------------------------
module hashed_handle_event_table_unit import hhet_pkg::*; #(
   parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF,
   parameter int HASH_BITS    = HASH_BITS_DEF,
   parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF
) (
   input logic        clock,
   input logic        reset,
   hhet_req_if.sink   req_ch,
   hhet_rsp_if.source rsp_ch
);

   // controller to datapath commands and datapath status
   ctl_type ctl;
   sts_type sts;

   // Sequencer: accept the request, step through the accesses, present the transfer
   hhet_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .ctl       (ctl),
      .sts       (sts)
   );

   // Memories, entry count and the response payload register
   hhet_dp #(
      .MAX_ENTRIES  (MAX_ENTRIES),
      .HASH_BITS    (HASH_BITS),
      .BUCKET_DEPTH (BUCKET_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .sts              (sts),
      .req_command      (req_ch.command),
      .req_handle       (req_ch.handle),
      .req_event_bits   (req_ch.event_bits),
      .rsp_status       (rsp_ch.status),
      .rsp_slot         (rsp_ch.slot),
      .rsp_events_now   (rsp_ch.events_now),
      .rsp_entries_used (rsp_ch.entries_used)
   );

endmodule
